FILE: rtl/core/hech_pkg.sv
// Package for the hall switch center homing block: item and config types,
// phase codes, field widths and register indexes.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package hech_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned POS_W   = 32;
    localparam int unsigned MS_W    = 16;
    localparam int unsigned MAG_W   = 31;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned CIDX_W  = 3;
    localparam int unsigned CDAT_W  = 31;

    // Register indexes of the configuration port
    localparam logic [CIDX_W-1:0] REG_SETTLE_MS    = 3'd0;
    localparam logic [CIDX_W-1:0] REG_STABLE_MS    = 3'd1;
    localparam logic [CIDX_W-1:0] REG_SEARCH_SPEED = 3'd2;
    localparam logic [CIDX_W-1:0] REG_LEAVE_DIST   = 3'd3;
    localparam logic [CIDX_W-1:0] REG_ARRIVE_TOL   = 3'd4;

    // Reset values of the registers
    localparam logic [MS_W-1:0]  RST_SETTLE_MS    = 16'd50;
    localparam logic [MS_W-1:0]  RST_STABLE_MS    = 16'd550;
    localparam logic [MAG_W-1:0] RST_SEARCH_SPEED = 31'd6554;
    localparam logic [MAG_W-1:0] RST_LEAVE_DIST   = 31'd6554;
    localparam logic [MAG_W-1:0] RST_ARRIVE_TOL   = 31'd655;

    typedef enum logic [PHASE_W-1:0] {
        PH_WAIT   = 3'd0,
        PH_MOVE   = 3'd1,
        PH_FIRST  = 3'd2,
        PH_SECOND = 3'd3,
        PH_RETURN = 3'd4,
        PH_DONE   = 3'd5
    } t_phase;

    typedef struct packed {
        logic [MS_W-1:0]  settle_ms;
        logic [MS_W-1:0]  stable_ms;
        logic [MAG_W-1:0] search_speed;
        logic [MAG_W-1:0] leave_distance;
        logic [MAG_W-1:0] arrive_tolerance;
    } t_cfg;

    typedef struct packed {
        logic                    hall_active;
        logic signed [POS_W-1:0] position;
        logic [TIME_W-1:0]       now_ms;
        logic                    motor_running;
    } t_in_item;

    typedef struct packed {
        logic [PHASE_W-1:0]      phase;
        logic                    velocity_write;
        logic signed [POS_W-1:0] velocity_value;
        logic                    enable_motor;
        logic                    disable_motor;
        logic                    position_write;
        logic signed [POS_W-1:0] position_preset;
        logic                    homing_done;
    } t_out_item;

endpackage

FILE: rtl/core/hech_if.sv
// Valid/ready channel interfaces for sample items and command items.
// Depends on hech_pkg for the payload types.
interface hech_in_if;
    logic                valid;
    logic                ready;
    hech_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hech_out_if;
    logic                valid;
    logic                ready;
    hech_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/hech_cfg.sv
// Configuration register bank of the homing block: decodes the write port
// and holds the five registers. Depends on hech_pkg.
module hech_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [hech_pkg::CIDX_W-1:0]   i_cfg_idx,
    input  logic [hech_pkg::CDAT_W-1:0]   i_cfg_data,
    output hech_pkg::t_cfg                o_cfg
);

    hech_pkg::t_cfg r_cfg;

    // Load the addressed register; drop writes to unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle_ms        <= hech_pkg::RST_SETTLE_MS;
            r_cfg.stable_ms        <= hech_pkg::RST_STABLE_MS;
            r_cfg.search_speed     <= hech_pkg::RST_SEARCH_SPEED;
            r_cfg.leave_distance   <= hech_pkg::RST_LEAVE_DIST;
            r_cfg.arrive_tolerance <= hech_pkg::RST_ARRIVE_TOL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hech_pkg::REG_SETTLE_MS:
                    r_cfg.settle_ms <= i_cfg_data[hech_pkg::MS_W-1:0];
                hech_pkg::REG_STABLE_MS:
                    r_cfg.stable_ms <= i_cfg_data[hech_pkg::MS_W-1:0];
                hech_pkg::REG_SEARCH_SPEED:
                    r_cfg.search_speed <= i_cfg_data[hech_pkg::MAG_W-1:0];
                hech_pkg::REG_LEAVE_DIST:
                    r_cfg.leave_distance <= i_cfg_data[hech_pkg::MAG_W-1:0];
                hech_pkg::REG_ARRIVE_TOL:
                    r_cfg.arrive_tolerance <= i_cfg_data[hech_pkg::MAG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/core/hall_edge_center_homing.sv
// Top level of the hall switch center homing sequencer: input stage, phase
// logic, result register. Depends on hech_pkg, hech_if.sv and hech_cfg.
//
//   channel   dir   modport  payload      handshake
//   i_in      in    sink     t_in_item    valid/ready, one sample tick
//   o_out     out   source   t_out_item   valid/ready, one command item
//   i_cfg_*   in    -        index/data   write enable, no wait
//
// Items pass s1 then the result register; one item per cycle unless stalled.
// The phase, trigger and edge registers update as an item leaves the input
// stage, so each item sees the state left by the one before it.
// Reset is synchronous: phase back to wait, no trigger, registers to defaults.
// A stalled result holds both stages; i_in.ready drops only when both are full.
module hall_edge_center_homing (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    hech_in_if.sink                       i_in,
    hech_out_if.source                    o_out,
    input  logic                          i_cfg_we,
    input  logic [hech_pkg::CIDX_W-1:0]   i_cfg_idx,
    input  logic [hech_pkg::CDAT_W-1:0]   i_cfg_data
);

    localparam int unsigned POS_W  = hech_pkg::POS_W;
    localparam int unsigned TIME_W = hech_pkg::TIME_W;

    hech_pkg::t_cfg       cfg;

    // Pipeline registers
    logic                 r_s1_vld;
    hech_pkg::t_in_item   r_s1_item;
    logic                 r_o_vld;
    hech_pkg::t_out_item  r_o_item;

    // Sequencer state
    hech_pkg::t_phase     r_phase, n_phase;
    logic                 r_trig_vld, n_trig_vld;
    logic [TIME_W-1:0]    r_trig_time, n_trig_time;
    logic signed [POS_W-1:0] r_first_edge, n_first_edge;

    logic                 o_free;
    logic                 s1_free;
    logic                 s1_fire;

    // Datapath terms
    logic [TIME_W-1:0]    elapsed;
    logic [POS_W-1:0]     pos_mag;
    logic signed [POS_W-1:0] speed_pos;
    logic signed [POS_W-1:0] speed_neg;
    logic signed [POS_W:0]   span;
    logic signed [POS_W:0]   half_span;
    logic                 hit_stable;
    logic                 hit_settle;
    logic                 is_off;
    logic                 is_home;
    hech_pkg::t_out_item  step_item;

    hech_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Handshake: each stage advances when the one after it has room
    assign o_free   = !r_o_vld || o_out.ready;
    assign s1_free  = !r_s1_vld || o_free;
    assign s1_fire  = r_s1_vld && o_free;
    assign i_in.ready = s1_free;

    // Compare terms from the staged sample
    assign elapsed    = r_s1_item.now_ms - r_trig_time;
    assign hit_stable = elapsed >= TIME_W'(cfg.stable_ms);
    assign hit_settle = elapsed >= TIME_W'(cfg.settle_ms);
    assign pos_mag    = r_s1_item.position[POS_W-1] ? (~r_s1_item.position + 1'b1)
                                                    : r_s1_item.position;
    assign is_off     = pos_mag >= POS_W'(cfg.leave_distance);
    assign is_home    = pos_mag < POS_W'(cfg.arrive_tolerance);
    assign speed_pos  = $signed(POS_W'(cfg.search_speed));
    assign speed_neg  = -speed_pos;

    // Half edge span, truncated toward zero; always fits POS_W, so no clamp
    assign span      = $signed({r_s1_item.position[POS_W-1], r_s1_item.position})
                     - $signed({r_first_edge[POS_W-1], r_first_edge});
    assign half_span = (span >>> 1) + $signed({{POS_W{1'b0}}, span[POS_W] & span[0]});

    // Next state of the sequencer
    always_comb begin
        n_phase      = r_phase;
        n_trig_vld   = r_trig_vld;
        n_trig_time  = r_trig_time;
        n_first_edge = r_first_edge;
        case (r_phase)
            hech_pkg::PH_WAIT: begin
                if (r_s1_item.hall_active) begin
                    if (!r_trig_vld) begin
                        n_trig_vld  = 1'b1;
                        n_trig_time = r_s1_item.now_ms;
                    end else if (hit_stable) begin
                        n_phase = hech_pkg::PH_MOVE;
                    end
                end else if (r_trig_vld) begin
                    n_trig_vld = 1'b0;
                end
            end
            hech_pkg::PH_MOVE: begin
                if (is_off) begin
                    n_phase = hech_pkg::PH_FIRST;
                end
            end
            hech_pkg::PH_FIRST: begin
                if (r_s1_item.hall_active) begin
                    n_first_edge = r_s1_item.position;
                    n_phase      = hech_pkg::PH_SECOND;
                end
            end
            hech_pkg::PH_SECOND: begin
                if (!r_s1_item.hall_active) begin
                    n_phase = hech_pkg::PH_RETURN;
                end
            end
            hech_pkg::PH_RETURN: begin
                if (is_home) begin
                    n_phase = hech_pkg::PH_DONE;
                end
            end
            default: begin
            end
        endcase
    end

    // Command fields of the result
    always_comb begin
        step_item = '0;
        case (r_phase)
            hech_pkg::PH_WAIT: begin
                if (r_s1_item.hall_active) begin
                    if (r_trig_vld) begin
                        if (hit_stable) begin
                            step_item.position_write = 1'b1;
                            step_item.velocity_write = 1'b1;
                            step_item.velocity_value = speed_neg;
                        end else if (hit_settle && !r_s1_item.motor_running) begin
                            step_item.enable_motor = 1'b1;
                        end
                    end
                end else if (r_trig_vld) begin
                    step_item.disable_motor = 1'b1;
                end
            end
            hech_pkg::PH_MOVE: begin
                if (is_off) begin
                    step_item.velocity_write = 1'b1;
                    step_item.velocity_value = speed_pos;
                end
            end
            hech_pkg::PH_SECOND: begin
                if (!r_s1_item.hall_active) begin
                    step_item.position_write  = 1'b1;
                    step_item.position_preset = half_span[POS_W-1:0];
                    step_item.velocity_write  = 1'b1;
                    step_item.velocity_value  = speed_neg;
                end
            end
            hech_pkg::PH_RETURN: begin
                if (is_home) begin
                    step_item.velocity_write = 1'b1;
                end
            end
            default: begin
            end
        endcase
        step_item.phase       = n_phase;
        step_item.homing_done = (n_phase == hech_pkg::PH_DONE);
    end

    // Control registers: stage valids and sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld     <= 1'b0;
            r_o_vld      <= 1'b0;
            r_phase      <= hech_pkg::PH_WAIT;
            r_trig_vld   <= 1'b0;
            r_trig_time  <= '0;
            r_first_edge <= '0;
        end else begin
            if (s1_free) begin
                r_s1_vld <= i_in.valid;
            end
            if (o_free) begin
                r_o_vld <= r_s1_vld;
            end
            if (s1_fire) begin
                r_phase      <= n_phase;
                r_trig_vld   <= n_trig_vld;
                r_trig_time  <= n_trig_time;
                r_first_edge <= n_first_edge;
            end
        end
    end

    // Payload registers: capture sample, then result
    always_ff @(posedge i_clk) begin
        if (s1_free && i_in.valid) begin
            r_s1_item <= i_in.data;
        end
        if (s1_fire) begin
            r_o_item <= step_item;
        end
    end

    assign o_out.valid = r_o_vld;
    assign o_out.data  = r_o_item;

    // Done is final until reset
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == hech_pkg::PH_DONE) |=> (r_phase == hech_pkg::PH_DONE))
        else $error("phase left done");

    // Phase moves forward by one step at most
    a_phase_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != $past(r_phase)) |->
        (r_phase == hech_pkg::t_phase'($past(r_phase) + 3'd1)))
        else $error("phase skipped or went back");

    // Phase changes only when an item passes the input stage
    a_phase_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_fire |=> $stable(r_phase))
        else $error("phase changed without an item");

    // Enable and disable never in the same result
    a_en_dis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld |-> !(r_o_item.enable_motor && r_o_item.disable_motor))
        else $error("enable and disable together");

    // Idle command fields read zero
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld |-> ((r_o_item.velocity_write || r_o_item.velocity_value == '0) &&
                     (r_o_item.position_write || r_o_item.position_preset == '0)))
        else $error("idle command field not zero");

endmodule

FILE: test/hech_cmd_monitor.sv
// Command monitor for the hall switch center homing block: predicts each command
// item from the accepted sample items and the config writes, then compares.
// Depends on hech_pkg and the channel interfaces in hech_if.sv.
module hech_cmd_monitor (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    hech_in_if                          in_ch,
    hech_out_if                         out_ch,
    input  logic                        i_cfg_we,
    input  logic [hech_pkg::CIDX_W-1:0] i_cfg_idx,
    input  logic [hech_pkg::CDAT_W-1:0] i_cfg_data,
    output int                          o_fail,
    output int                          o_pending
);
    import hech_pkg::*;

    localparam longint POS_HI = (longint'(1) <<< (POS_W - 1)) - 1;
    localparam longint POS_LO = -POS_HI - 1;

    // Shadow copy of the sequencer state and its registers
    t_cfg                    cfg_q;
    t_phase                  phase_q;
    logic                    trig_seen;
    logic [TIME_W-1:0]       trig_ms;
    logic signed [POS_W-1:0] first_pos;
    t_out_item               cmd_q[$];
    int                      fail_cnt = 0;

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Advance the shadow sequencer by one sample and return the command it issues
    function automatic t_out_item next_command(t_in_item s);
        t_out_item         c;
        logic [TIME_W-1:0] elapsed;
        longint            spd;
        longint            pos;
        longint            span;
        c   = '0;
        spd = longint'(cfg_q.search_speed);
        pos = longint'($signed(s.position));
        case (phase_q)
            PH_WAIT: begin
                if (s.hall_active) begin
                    if (!trig_seen) begin
                        // a trigger at timestamp zero counts like any other
                        trig_seen = 1'b1;
                        trig_ms   = s.now_ms;
                    end else begin
                        elapsed = s.now_ms - trig_ms;
                        if (elapsed >= cfg_q.stable_ms) begin
                            c.position_write = 1'b1;
                            c.velocity_write = 1'b1;
                            c.velocity_value = POS_W'(-spd);
                            phase_q          = PH_MOVE;
                        end else if (elapsed >= cfg_q.settle_ms && !s.motor_running) begin
                            c.enable_motor = 1'b1;
                        end
                    end
                end else if (trig_seen) begin
                    // bounce: forget the trigger and stop the driver
                    trig_seen       = 1'b0;
                    c.disable_motor = 1'b1;
                end
            end
            PH_MOVE: begin
                if (mag(pos) >= longint'(cfg_q.leave_distance)) begin
                    c.velocity_write = 1'b1;
                    c.velocity_value = POS_W'(spd);
                    phase_q          = PH_FIRST;
                end
            end
            PH_FIRST: begin
                if (s.hall_active) begin
                    first_pos = s.position;
                    phase_q   = PH_SECOND;
                end
            end
            PH_SECOND: begin
                if (!s.hall_active) begin
                    // half span, truncated toward zero, clamped to the position range
                    span = (pos - longint'(first_pos)) / 2;
                    if (span > POS_HI) span = POS_HI;
                    if (span < POS_LO) span = POS_LO;
                    c.position_write  = 1'b1;
                    c.position_preset = POS_W'(span);
                    c.velocity_write  = 1'b1;
                    c.velocity_value  = POS_W'(-spd);
                    phase_q           = PH_RETURN;
                end
            end
            PH_RETURN: begin
                if (mag(pos) < longint'(cfg_q.arrive_tolerance)) begin
                    c.velocity_write = 1'b1;
                    phase_q          = PH_DONE;
                end
            end
            default: ;
        endcase
        c.phase       = phase_q;
        c.homing_done = (phase_q >= PH_DONE);
        return c;
    endfunction

    task automatic check_field(string name, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_cnt++;
        end
    endtask

    // Track config writes, compare outgoing items, queue predictions
    always @(posedge i_clk) begin : track
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            cfg_q.settle_ms        = RST_SETTLE_MS;
            cfg_q.stable_ms        = RST_STABLE_MS;
            cfg_q.search_speed     = RST_SEARCH_SPEED;
            cfg_q.leave_distance   = RST_LEAVE_DIST;
            cfg_q.arrive_tolerance = RST_ARRIVE_TOL;
            phase_q   = PH_WAIT;
            trig_seen = 1'b0;
            trig_ms   = '0;
            first_pos = '0;
            cmd_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SETTLE_MS:    cfg_q.settle_ms        = i_cfg_data[MS_W-1:0];
                    REG_STABLE_MS:    cfg_q.stable_ms        = i_cfg_data[MS_W-1:0];
                    REG_SEARCH_SPEED: cfg_q.search_speed     = i_cfg_data[MAG_W-1:0];
                    REG_LEAVE_DIST:   cfg_q.leave_distance   = i_cfg_data[MAG_W-1:0];
                    REG_ARRIVE_TOL:   cfg_q.arrive_tolerance = i_cfg_data[MAG_W-1:0];
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                if (cmd_q.size() == 0) begin
                    $display("%0t: command item with nothing expected, expected none, actual %h",
                             $time, got);
                    fail_cnt++;
                end else begin
                    want = cmd_q.pop_front();
                    check_field("phase", POS_W'(want.phase), POS_W'(got.phase));
                    check_field("velocity_write", POS_W'(want.velocity_write),
                                POS_W'(got.velocity_write));
                    check_field("velocity_value", want.velocity_value, got.velocity_value);
                    check_field("enable_motor", POS_W'(want.enable_motor),
                                POS_W'(got.enable_motor));
                    check_field("disable_motor", POS_W'(want.disable_motor),
                                POS_W'(got.disable_motor));
                    check_field("position_write", POS_W'(want.position_write),
                                POS_W'(got.position_write));
                    check_field("position_preset", want.position_preset, got.position_preset);
                    check_field("homing_done", POS_W'(want.homing_done),
                                POS_W'(got.homing_done));
                end
            end
            if (in_ch.valid && in_ch.ready) cmd_q.push_back(next_command(in_ch.data));
        end
        o_fail    <= fail_cnt;
        o_pending <= cmd_q.size();
    end

endmodule

FILE: test/hall_edge_center_homing_tb.sv
// Top of the homing sequencer testbench: clock, reset, sample stimulus, config
// writes, command stalls, watchdog and verdict. Depends on hech_pkg, hech_if.sv,
// hech_cmd_monitor and the block itself.
module hall_edge_center_homing_tb;
    import hech_pkg::*;

    localparam int IDLE_LIMIT  = 3000;
    localparam int HOLD_AT     = 120;
    localparam int HOLD_CYCLES = 300;
    localparam logic [CIDX_W-1:0] IDX_UNUSED = REG_ARRIVE_TOL + 3'd1;

    logic              i_clk    = 1'b0;
    logic              i_rst_n  = 1'b0;
    logic              cfg_we   = 1'b0;
    logic [CIDX_W-1:0] cfg_idx  = '0;
    logic [CDAT_W-1:0] cfg_data = '0;

    int                fails;
    int                pending;
    int                burst_left  = 0;
    int                idle_cycles = 0;
    logic [TIME_W-1:0] clock_ms    = '0;

    hech_in_if  sample_ch ();
    hech_out_if cmd_ch ();

    always #10 i_clk = ~i_clk;

    hall_edge_center_homing u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (sample_ch),
        .o_out      (cmd_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    hech_cmd_monitor u_mon (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_ch      (sample_ch),
        .out_ch     (cmd_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_fail     (fails),
        .o_pending  (pending)
    );

    // Random single bit
    function automatic bit coin();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic t_in_item mk_sample(bit hall, logic [POS_W-1:0] pos,
                                           logic [TIME_W-1:0] now, bit run);
        t_in_item s;
        s.hall_active   = hall;
        s.position      = pos;
        s.now_ms        = now;
        s.motor_running = run;
        return s;
    endfunction

    // Offer one sample item in bursts with random gaps; return once it is taken
    task automatic push_sample(t_in_item s);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                sample_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        sample_ch.valid <= 1'b1;
        sample_ch.data  <= s;
        do @(posedge i_clk); while (!sample_ch.ready);
        burst_left--;
    endtask

    // Stop offering and wait until every command item has come out
    task automatic drain();
        sample_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait-phase traffic: mostly steady triggers with short steps, bounces that
    // sometimes jump the timestamp anywhere
    task automatic wait_noise(int n);
        bit hall;
        for (int k = 0; k < n; k++) begin
            hall = ($urandom_range(0, 3) != 0);
            if (hall) clock_ms = clock_ms + $urandom_range(0, 200);
            else if ($urandom_range(0, 7) == 0) clock_ms = $urandom;
            else clock_ms = clock_ms + $urandom_range(0, 1000);
            push_sample(mk_sample(hall, $urandom, clock_ms, coin()));
        end
    endtask

    // Random positions that stay below a full-scale leave distance
    function automatic logic [POS_W-1:0] inner_pos();
        logic [POS_W-1:0] p;
        p = $urandom;
        if (p == 32'h7FFF_FFFF || p == 32'h8000_0000 || p == 32'h8000_0001) p = '0;
        return p;
    endfunction

    // Stimulus
    initial begin : stimulus
        logic [TIME_W-1:0] t0;
        sample_ch.valid = 1'b0;
        sample_ch.data  = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait phase at reset settings: timestamp zero, settle, running, bounce, wrap
        push_sample(mk_sample(1'b0, 32'h0000_0000, 32'd5, 1'b0));
        push_sample(mk_sample(1'b1, 32'h7FFF_FFFF, 32'd0, 1'b0));
        push_sample(mk_sample(1'b1, 32'h8000_0000, 32'd49, 1'b0));
        push_sample(mk_sample(1'b1, 32'hFFFF_FFFF, 32'd50, 1'b0));
        push_sample(mk_sample(1'b1, 32'h0000_0000, 32'd60, 1'b1));
        push_sample(mk_sample(1'b0, 32'h0000_0001, 32'd70, 1'b0));
        push_sample(mk_sample(1'b0, 32'h0000_0000, 32'd80, 1'b1));
        push_sample(mk_sample(1'b1, 32'h0000_0000, 32'hFFFF_FFF0, 1'b1));
        push_sample(mk_sample(1'b1, 32'h0000_0000, 32'h0000_0021, 1'b0));
        push_sample(mk_sample(1'b1, 32'h0000_0000, 32'h0000_0022, 1'b0));
        push_sample(mk_sample(1'b1, 32'h0000_0000, 32'h0000_0215, 1'b0));
        push_sample(mk_sample(1'b0, 32'h0000_0000, 32'h0000_0300, 1'b0));

        // Settle at zero, stable at its top; junk above the register width and
        // writes to unused indexes
        drain();
        write_reg(REG_SETTLE_MS, 31'h7FFF_0000);
        write_reg(REG_STABLE_MS, 31'h7FFF_FFFF);
        write_reg(REG_LEAVE_DIST, 31'h0);
        write_reg(REG_ARRIVE_TOL, CDAT_W'($urandom));
        for (int j = 0; j < 3; j++) write_reg(IDX_UNUSED + CIDX_W'(j), CDAT_W'($urandom));
        wait_noise(160);

        drain();
        write_reg(REG_SETTLE_MS, CDAT_W'($urandom_range(100, 600)));
        write_reg(REG_SEARCH_SPEED, CDAT_W'($urandom));
        wait_noise(160);

        // One full homing pass: exit wait at once, full-scale speed and leave distance
        drain();
        write_reg(REG_SETTLE_MS, 31'd20);
        write_reg(REG_STABLE_MS, 31'd0);
        write_reg(REG_SEARCH_SPEED, 31'h7FFF_FFFF);
        write_reg(REG_LEAVE_DIST, 31'h7FFF_FFFF);
        write_reg(REG_ARRIVE_TOL, 31'd0);
        t0 = $urandom;
        push_sample(mk_sample(1'b0, $urandom, t0, coin()));
        push_sample(mk_sample(1'b1, $urandom, t0 + 1, coin()));
        push_sample(mk_sample(1'b1, $urandom, t0 + 2, coin()));

        // Move off: stay short of the leave distance, then zero speed on exit
        repeat ($urandom_range(6, 14))
            push_sample(mk_sample(coin(), inner_pos(), $urandom, coin()));
        push_sample(mk_sample(1'b0, 32'h7FFF_FFFE, $urandom, 1'b0));
        push_sample(mk_sample(1'b1, 32'h8000_0002, $urandom, 1'b1));
        drain();
        write_reg(REG_SEARCH_SPEED, 31'd0);
        push_sample(mk_sample(1'b0, 32'h8000_0001, $urandom, 1'b0));

        // First edge at the top of the position range
        repeat ($urandom_range(6, 14))
            push_sample(mk_sample(1'b0, $urandom, $urandom, coin()));
        push_sample(mk_sample(1'b1, 32'h7FFF_FFFF, $urandom, 1'b1));

        // Closing edge at the bottom: odd negative span truncates toward zero
        drain();
        write_reg(REG_SEARCH_SPEED, CDAT_W'($urandom_range(1, 32'h7FFF_FFFE)));
        write_reg(REG_LEAVE_DIST, 31'd0);
        repeat ($urandom_range(6, 14))
            push_sample(mk_sample(1'b1, $urandom, $urandom, coin()));
        push_sample(mk_sample(1'b0, 32'h8000_0000, $urandom, 1'b0));

        // Return with zero tolerance never arrives; full-scale tolerance does
        repeat ($urandom_range(6, 14))
            push_sample(mk_sample(coin(), $urandom, $urandom, coin()));
        push_sample(mk_sample(1'b0, 32'h0000_0000, $urandom, 1'b0));
        drain();
        write_reg(REG_ARRIVE_TOL, 31'h7FFF_FFFF);
        push_sample(mk_sample(1'b0, 32'h8000_0000, $urandom, 1'b0));
        push_sample(mk_sample(1'b1, 32'h7FFF_FFFF, $urandom, 1'b1));
        push_sample(mk_sample(1'b0, 32'h8000_0001, $urandom, 1'b0));
        push_sample(mk_sample(1'b1, $urandom_range(0, 65535), $urandom, 1'b1));

        // Done phase holds whatever comes in or gets written
        drain();
        write_reg(REG_SETTLE_MS, 31'h7FFF_FFFF);
        write_reg(REG_STABLE_MS, 31'h5555_0000);
        write_reg(REG_SEARCH_SPEED, CDAT_W'($urandom));
        write_reg(REG_LEAVE_DIST, CDAT_W'($urandom));
        write_reg(REG_ARRIVE_TOL, CDAT_W'($urandom));
        write_reg(IDX_UNUSED, 31'h7FFF_FFFF);
        repeat (100)
            push_sample(mk_sample(coin(), $urandom, $urandom, coin()));

        drain();
        repeat (5) @(posedge i_clk);
        if (fails == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Command side stalls: a ready mode redrawn at random, one long hold-off
    initial begin : receiver
        int          got;
        int          cyc;
        int          mode;
        bit          held;
        logic [7:0]  pat;
        got  = 0;
        cyc  = 0;
        mode = 0;
        held = 1'b0;
        pat  = 8'b1011_0010;
        cmd_ch.ready = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            @(posedge i_clk);
            if (cmd_ch.valid && cmd_ch.ready) got++;
            if (!held && got >= HOLD_AT) begin
                // hold off while samples keep coming so the block backs up
                held = 1'b1;
                cmd_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (cyc % 64 == 0) mode = $urandom_range(0, 3);
                cyc++;
                case (mode)
                    0: cmd_ch.ready <= 1'b1;
                    1: cmd_ch.ready <= coin();
                    2: cmd_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: begin
                        pat = {pat[6:0], pat[7]};
                        cmd_ch.ready <= pat[0];
                    end
                endcase
            end
        end
    end

    // Watchdog: end the run after too long without any item moving
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((sample_ch.valid && sample_ch.ready) || (cmd_ch.valid && cmd_ch.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles == IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule
